@@ sv/sdpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpa_pkg
// Shared widths, constants, register codes and handoff types for the
// straight-drive PID controller with side alignment.
// ----------------------------------------------------------------------------
package sdpa_pkg;

    // Gain format: unsigned Q4.16
    localparam int GAIN_W    = 20;
    localparam int GAIN_FRAC = 16;

    // Power clamp register width (percent)
    localparam int POWER_W = 7;

    // Saturating error accumulator
    localparam int SUM_W = 40;

    // Working width of the Q.16 power datapath
    localparam int PWR_W = 64;

    // Clamped power fits below 128 percent in Q.16
    localparam int CLAMP_W = POWER_W + GAIN_FRAC;

    // Millivolt output
    localparam int MV_W        = 15;
    localparam int MIN_POWER   = 5;
    localparam int MV_PER_PCT  = 120;
    localparam int MV_LIMIT    = 12000;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET     = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_GAIN_ALIGN = 3'd4,
        REG_MAX_POWER  = 3'd5,
        REG_REVERSE    = 3'd6,
        REG_SHORT_MOVE = 3'd7
    } cfg_reg_t;

    // Gain and mode settings seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [GAIN_W-1:0]  gain_align;
        logic [POWER_W-1:0] max_power;
        logic               reverse;
        logic               short_move;
    } gain_set_t;

    // Per-stage load strobes from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_load_t;

endpackage

@@ sv/straight_drive_pid_with_alignment.sv @@
`timescale 1ns / 1ps
// Result path: five register stages (operands, products, clamp, scale, result) behind the input transfer.
// Throughput: one item per cycle when the output is not backpressured; the state update closes in the first stage.
// Each stage holds its item under output backpressure and frees as it drains.
// Reset: config registers take defaults (max_power 100, others 0), the controller is
// idle and reports done until a start request arrives; pipeline is emptied.
// ----------------------------------------------------------------------------
// straight_drive_pid_with_alignment
// Differential-drive PID position controller with side alignment: config
// registers, pipeline handshake control and the datapath stages.
// ----------------------------------------------------------------------------
module straight_drive_pid_with_alignment #(
    parameter int TICK_BITS = 20,
    localparam int CFG_W = (TICK_BITS > sdpa_pkg::GAIN_W) ? TICK_BITS : sdpa_pkg::GAIN_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [sdpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]                   cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               start_req,
    input  logic [TICK_BITS-1:0]               left_ticks,
    input  logic [TICK_BITS-1:0]               right_ticks,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [sdpa_pkg::MV_W-1:0]   left_drive_mv,
    output logic signed [sdpa_pkg::MV_W-1:0]   right_drive_mv,
    output logic                               done_res
);
    import sdpa_pkg::*;

    localparam int NSTAGE = 5;

    // Configuration registers
    logic [TICK_BITS-1:0] target_ticks_reg;
    gain_set_t            gains_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_ticks_reg     <= '0;
            gains_reg.gain_p     <= '0;
            gains_reg.gain_i     <= '0;
            gains_reg.gain_d     <= '0;
            gains_reg.gain_align <= '0;
            gains_reg.max_power  <= POWER_W'(100);
            gains_reg.reverse    <= 1'b0;
            gains_reg.short_move <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET:     target_ticks_reg     <= cfg_data[TICK_BITS-1:0];
                REG_GAIN_P:     gains_reg.gain_p     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     gains_reg.gain_i     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     gains_reg.gain_d     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_ALIGN: gains_reg.gain_align <= cfg_data[GAIN_W-1:0];
                REG_MAX_POWER:  gains_reg.max_power  <= cfg_data[POWER_W-1:0];
                REG_REVERSE:    gains_reg.reverse    <= cfg_data[0];
                REG_SHORT_MOVE: gains_reg.short_move <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Pipeline occupancy and per-stage ready
    logic [NSTAGE-1:0] vld_reg, vld_next;
    logic [NSTAGE-1:0] rdy;
    logic [NSTAGE-1:0] ld;
    stage_load_t       stage_load;

    always_comb
    begin
        rdy[NSTAGE-1] = !vld_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ld[0]       = in_valid && rdy[0];
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            ld[k]       = vld_reg[k-1] && rdy[k];
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
        stage_load.s1 = ld[0];
        stage_load.s2 = ld[1];
        stage_load.s3 = ld[2];
        stage_load.s4 = ld[3];
        stage_load.s5 = ld[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTAGE-1];

    // Stage 1: move state
    logic                             s1_done;
    logic signed [TICK_BITS:0]        s1_dist, s1_last;
    logic signed [SUM_W-1:0]          s1_sum;
    logic [TICK_BITS-1:0]             s1_left, s1_right;

    sdpa_track #(
        .TICK_BITS (TICK_BITS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (stage_load.s1),
        .start_req    (start_req),
        .left_ticks   (left_ticks),
        .right_ticks  (right_ticks),
        .target_ticks (target_ticks_reg),
        .s1_done      (s1_done),
        .s1_dist      (s1_dist),
        .s1_last      (s1_last),
        .s1_sum       (s1_sum),
        .s1_left      (s1_left),
        .s1_right     (s1_right)
    );

    // Stage 2: products
    logic                                 s2_done;
    logic signed [TICK_BITS+GAIN_W+2:0]   s2_p_term, s2_d_term;
    logic signed [SUM_W+GAIN_W:0]         s2_i_term;
    logic [TICK_BITS+GAIN_W-1:0]          s2_align;
    logic                                 s2_left_ahead, s2_right_ahead;

    sdpa_products #(
        .TICK_BITS (TICK_BITS)
    ) u_products (
        .clk            (clk),
        .load           (stage_load.s2),
        .gains          (gains_reg),
        .s1_done        (s1_done),
        .s1_dist        (s1_dist),
        .s1_last        (s1_last),
        .s1_sum         (s1_sum),
        .s1_left        (s1_left),
        .s1_right       (s1_right),
        .s2_done        (s2_done),
        .s2_p_term      (s2_p_term),
        .s2_i_term      (s2_i_term),
        .s2_d_term      (s2_d_term),
        .s2_align       (s2_align),
        .s2_left_ahead  (s2_left_ahead),
        .s2_right_ahead (s2_right_ahead)
    );

    // Stages 3 to 5: clamp, align, scale, result
    sdpa_drive #(
        .TICK_BITS (TICK_BITS)
    ) u_drive (
        .clk            (clk),
        .load           (stage_load),
        .gains          (gains_reg),
        .s2_done        (s2_done),
        .s2_p_term      (s2_p_term),
        .s2_i_term      (s2_i_term),
        .s2_d_term      (s2_d_term),
        .s2_align       (s2_align),
        .s2_left_ahead  (s2_left_ahead),
        .s2_right_ahead (s2_right_ahead),
        .left_drive_mv  (left_drive_mv),
        .right_drive_mv (right_drive_mv),
        .done_res       (done_res)
    );

`ifndef SYNTH
    // Finished moves drive nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> (left_drive_mv == '0) && (right_drive_mv == '0))
        else $error("drive output nonzero on done result");

    // Output stays within the voltage limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_drive_mv <= 15'sd12000) && (left_drive_mv >= -15'sd12000)
                   && (right_drive_mv <= 15'sd12000) && (right_drive_mv >= -15'sd12000))
        else $error("drive output beyond voltage limit");

    // Input backpressure only when every stage is full and the result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&vld_reg) && !out_ready)
        else $error("input stalled with room in the pipeline");

    // A transfer at the input always lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted item lost at the first stage");
`endif

endmodule

@@ sv/sdpa_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpa_track
// Move state tracking: error, error sum, finish detection. Updates on each
// input transfer and registers the resulting operands for the datapath.
// ----------------------------------------------------------------------------
module sdpa_track #(
    parameter int TICK_BITS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 start_req,
    input  logic [TICK_BITS-1:0]                 left_ticks,
    input  logic [TICK_BITS-1:0]                 right_ticks,
    input  logic [TICK_BITS-1:0]                 target_ticks,
    output logic                                 s1_done,
    output logic signed [TICK_BITS:0]            s1_dist,
    output logic signed [TICK_BITS:0]            s1_last,
    output logic signed [sdpa_pkg::SUM_W-1:0]    s1_sum,
    output logic [TICK_BITS-1:0]                 s1_left,
    output logic [TICK_BITS-1:0]                 s1_right
);
    import sdpa_pkg::*;

    logic [TICK_BITS-1:0]     left_seen_reg,  left_seen_next;
    logic [TICK_BITS-1:0]     right_seen_reg, right_seen_next;
    logic signed [TICK_BITS:0] dist_error_reg, dist_error_next;
    logic signed [TICK_BITS:0] last_error_reg, last_error_next;
    logic signed [SUM_W-1:0]  error_sum_reg,  error_sum_next;
    logic                     finished_reg,   finished_next;
    logic                     done_next;

    logic [TICK_BITS:0]        tick_total;
    logic [TICK_BITS-1:0]      avg;
    logic signed [TICK_BITS:0] err_now;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;

    // Average, new error and saturating accumulation
    always_comb
    begin
        tick_total = {1'b0, left_ticks} + {1'b0, right_ticks};
        avg        = tick_total[TICK_BITS:1];
        err_now    = $signed({1'b0, target_ticks}) - $signed({1'b0, avg});
        sum_wide   = $signed({error_sum_reg[SUM_W-1], error_sum_reg})
                   + $signed({{(SUM_W-TICK_BITS){dist_error_reg[TICK_BITS]}},
                              dist_error_reg});
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // Next move state
    always_comb
    begin
        left_seen_next  = left_seen_reg;
        right_seen_next = right_seen_reg;
        dist_error_next = dist_error_reg;
        last_error_next = last_error_reg;
        error_sum_next  = error_sum_reg;
        finished_next   = finished_reg;
        done_next       = 1'b1;
        if (start_req)
        begin
            left_seen_next  = '0;
            right_seen_next = '0;
            dist_error_next = '0;
            last_error_next = '0;
            error_sum_next  = '0;
            finished_next   = (target_ticks == '0);
            done_next       = finished_next;
        end
        else if (!finished_reg)
        begin
            left_seen_next  = left_ticks;
            right_seen_next = right_ticks;
            last_error_next = dist_error_reg;
            error_sum_next  = sum_sat;
            dist_error_next = err_now;
            finished_next   = (avg >= target_ticks);
            done_next       = finished_next;
        end
    end

    // Move state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_seen_reg  <= '0;
            right_seen_reg <= '0;
            dist_error_reg <= '0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
            finished_reg   <= 1'b1;
        end
        else if (load)
        begin
            left_seen_reg  <= left_seen_next;
            right_seen_reg <= right_seen_next;
            dist_error_reg <= dist_error_next;
            last_error_reg <= last_error_next;
            error_sum_reg  <= error_sum_next;
            finished_reg   <= finished_next;
        end
    end

    // Stage 1 operand register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_done  <= done_next;
            s1_dist  <= dist_error_next;
            s1_last  <= last_error_next;
            s1_sum   <= error_sum_next;
            s1_left  <= left_seen_next;
            s1_right <= right_seen_next;
        end
    end

endmodule

@@ sv/sdpa_products.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpa_products
// Gain multiplies: P, I, D terms and the side alignment correction,
// each registered.
// ----------------------------------------------------------------------------
module sdpa_products #(
    parameter int TICK_BITS = 20
) (
    input  logic                                       clk,
    input  logic                                       load,
    input  sdpa_pkg::gain_set_t                        gains,
    input  logic                                       s1_done,
    input  logic signed [TICK_BITS:0]                  s1_dist,
    input  logic signed [TICK_BITS:0]                  s1_last,
    input  logic signed [sdpa_pkg::SUM_W-1:0]          s1_sum,
    input  logic [TICK_BITS-1:0]                       s1_left,
    input  logic [TICK_BITS-1:0]                       s1_right,
    output logic                                       s2_done,
    output logic signed [TICK_BITS+sdpa_pkg::GAIN_W+2:0]   s2_p_term,
    output logic signed [sdpa_pkg::SUM_W+sdpa_pkg::GAIN_W:0] s2_i_term,
    output logic signed [TICK_BITS+sdpa_pkg::GAIN_W+2:0]   s2_d_term,
    output logic [TICK_BITS+sdpa_pkg::GAIN_W-1:0]          s2_align,
    output logic                                       s2_left_ahead,
    output logic                                       s2_right_ahead
);
    import sdpa_pkg::*;

    logic [GAIN_W:0]                    kp;
    logic signed [TICK_BITS+1:0]        err_delta;
    logic [TICK_BITS-1:0]               side_diff;
    logic signed [TICK_BITS+GAIN_W+2:0] p_prod;
    logic signed [SUM_W+GAIN_W:0]       i_prod;
    logic signed [TICK_BITS+GAIN_W+2:0] d_prod;
    logic [TICK_BITS+GAIN_W-1:0]        a_prod;

    // Operand prep and multiplies
    always_comb
    begin
        kp        = gains.short_move ? {gains.gain_p, 1'b0} : {1'b0, gains.gain_p};
        err_delta = $signed({s1_dist[TICK_BITS], s1_dist})
                  - $signed({s1_last[TICK_BITS], s1_last});
        side_diff = (s1_left > s1_right) ? (s1_left - s1_right) : (s1_right - s1_left);
        p_prod    = s1_dist * $signed({1'b0, kp});
        i_prod    = s1_sum * $signed({1'b0, gains.gain_i});
        d_prod    = err_delta * $signed({1'b0, gains.gain_d});
        a_prod    = side_diff * gains.gain_align;
    end

    // Stage 2 register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_done        <= s1_done;
            s2_p_term      <= p_prod;
            s2_i_term      <= i_prod;
            s2_d_term      <= d_prod;
            s2_align       <= a_prod;
            s2_left_ahead  <= (s1_left > s1_right);
            s2_right_ahead <= (s1_right > s1_left);
        end
    end

endmodule

@@ sv/sdpa_drive.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpa_drive
// Power sum and clamp, side alignment and direction, millivolt scaling and
// saturation into the result register.
// ----------------------------------------------------------------------------
module sdpa_drive #(
    parameter int TICK_BITS = 20
) (
    input  logic                                          clk,
    input  sdpa_pkg::stage_load_t                         load,
    input  sdpa_pkg::gain_set_t                           gains,
    input  logic                                          s2_done,
    input  logic signed [TICK_BITS+sdpa_pkg::GAIN_W+2:0]     s2_p_term,
    input  logic signed [sdpa_pkg::SUM_W+sdpa_pkg::GAIN_W:0] s2_i_term,
    input  logic signed [TICK_BITS+sdpa_pkg::GAIN_W+2:0]     s2_d_term,
    input  logic [TICK_BITS+sdpa_pkg::GAIN_W-1:0]            s2_align,
    input  logic                                          s2_left_ahead,
    input  logic                                          s2_right_ahead,
    output logic signed [sdpa_pkg::MV_W-1:0]              left_drive_mv,
    output logic signed [sdpa_pkg::MV_W-1:0]              right_drive_mv,
    output logic                                          done_res
);
    import sdpa_pkg::*;

    localparam int PW = PWR_W;
    localparam int AW = TICK_BITS + GAIN_W;
    localparam logic signed [PW-1:0] MIN_Q  = PW'(MIN_POWER * (2 ** GAIN_FRAC));
    localparam logic signed [PW-1:0] LIM_Q  = PW'(MV_LIMIT * (2 ** GAIN_FRAC));
    localparam logic signed [MV_W-1:0] MV_MAX = MV_W'(MV_LIMIT);

    // Q.16 power to millivolts: saturate, truncate toward zero
    function automatic logic signed [MV_W-1:0] to_mv(input logic signed [PW-1:0] v);
        logic [PW-1:0]   mag;
        logic [MV_W-1:0] q;
        mag = v[PW-1] ? (~v + 1'b1) : v;
        q   = {1'b0, mag[GAIN_FRAC +: MV_W-1]};
        if (v >= LIM_Q)
        begin
            return MV_MAX;
        end
        else if (v <= -LIM_Q)
        begin
            return -MV_MAX;
        end
        else if (v[PW-1])
        begin
            return -$signed(q);
        end
        else
        begin
            return $signed(q);
        end
    endfunction

    // Stage 3 signals
    logic signed [PW-1:0] p_ext, i_ext, d_ext, p_sum, max_q;
    logic [CLAMP_W-1:0]   clamp_val;
    logic                 s3_done;
    logic [CLAMP_W-1:0]   s3_clamp;
    logic [AW-1:0]        s3_align;
    logic                 s3_left_ahead, s3_right_ahead;

    // Stage 4 signals
    logic signed [PW-1:0] clamp_ext, align_ext, lp, rp, lv, rv;
    logic                 s4_done;
    logic signed [PW-1:0] s4_lv, s4_rv;

    // PID sum and power clamp
    always_comb
    begin
        p_ext = PW'(s2_p_term);
        i_ext = PW'(s2_i_term);
        d_ext = PW'(s2_d_term);
        p_sum = p_ext + i_ext + d_ext;
        max_q = $signed({{(PW-CLAMP_W){1'b0}}, gains.max_power, {GAIN_FRAC{1'b0}}});
        if (p_sum > max_q)
        begin
            clamp_val = max_q[CLAMP_W-1:0];
        end
        else if (p_sum < MIN_Q)
        begin
            clamp_val = MIN_Q[CLAMP_W-1:0];
        end
        else
        begin
            clamp_val = p_sum[CLAMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s3)
        begin
            s3_done        <= s2_done;
            s3_clamp       <= clamp_val;
            s3_align       <= s2_align;
            s3_left_ahead  <= s2_left_ahead;
            s3_right_ahead <= s2_right_ahead;
        end
    end

    // Slow the leading side, apply direction, scale by 120
    always_comb
    begin
        clamp_ext = $signed({{(PW-CLAMP_W){1'b0}}, s3_clamp});
        align_ext = $signed({{(PW-AW){1'b0}}, s3_align});
        lp = s3_left_ahead  ? (clamp_ext - align_ext) : clamp_ext;
        rp = s3_right_ahead ? (clamp_ext - align_ext) : clamp_ext;
        if (gains.reverse)
        begin
            lp = -lp;
            rp = -rp;
        end
        // 120 = 128 - 8
        lv = (lp <<< 7) - (lp <<< 3);
        rv = (rp <<< 7) - (rp <<< 3);
    end

    always_ff @(posedge clk)
    begin
        if (load.s4)
        begin
            s4_done <= s3_done;
            s4_lv   <= lv;
            s4_rv   <= rv;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load.s5)
        begin
            done_res       <= s4_done;
            left_drive_mv  <= s4_done ? '0 : to_mv(s4_lv);
            right_drive_mv <= s4_done ? '0 : to_mv(s4_rv);
        end
    end

endmodule
